### design/sha256_pkg.sv
// sha256_pkg: types, constants and helper functions for the byte stream sha-256 hasher
// no dependencies
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef logic [31:0] word_t;

  function automatic word_t init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### design/sha256_byte_stream_hasher_top.sv
// sha256_byte_stream_hasher_top: byte fed sha-256 with padding and digest readout
// depends on sha256_pkg
//
// A byte transaction that does not complete a 64-byte block leaves the hasher
// idle, and the next transaction can follow at once. A byte that completes a block
// holds the input off while the block is compressed: the working registers are
// loaded, 64 compression rounds run at one per cycle on a single shared round
// unit, and the chaining add follows. Message bytes are packed directly into the
// 16-word schedule window, so there is no separate block buffer. A finish
// transaction runs the padding bytes one per cycle through the same path,
// with one or two compressions. It then presents the eight digest words most
// significant first, each held while out_stall is high. The next transaction
// is taken once the last word goes.
module sha256_byte_stream_hasher_top import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        finish,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  state_t state, state_next;

  word_t       chain [8];
  word_t       v [8];
  word_t       w [16];
  logic [63:0] bit_total;
  logic [63:0] len_latch;
  logic        msg_end;
  logic        fin_pending;
  logic        len_phase;
  logic [6:0]  cnt;
  logic [2:0]  oidx;

  logic [5:0]  pos;
  logic        in_acc;
  logic        pad_step;
  logic [7:0]  pad_byte_val;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        block_full;
  word_t       ws_new, wk, t1, t2;

  assign pos = bit_total[8:3];
  assign in_stall = (state != ST_IDLE);
  assign in_acc = in_valid && (state == ST_IDLE);
  assign pad_step = (state == ST_PAD);

  // padding byte for current position
  always_comb begin
    if (!fin_pending) begin
      pad_byte_val = PAD_BYTE;
    end else if (len_phase || pos == LEN_POS) begin
      pad_byte_val = len_latch[{~pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte_val = 8'h00;
    end
  end

  // byte write into the schedule window
  always_comb begin
    wr_en = 1'b0;
    wr_byte = data_byte;
    if (in_acc && byte_present) begin
      wr_en = 1'b1;
    end else if (pad_step) begin
      wr_en = 1'b1;
      wr_byte = pad_byte_val;
    end
  end
  assign block_full = wr_en && (pos == 6'd63);

  // message schedule and round unit
  always_comb begin
    ws_new = (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10)) + w[9]
           + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[0];
    wk = (cnt < 7'd16) ? w[cnt[3:0]] : ws_new;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[cnt[5:0]] + wk;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (block_full) state_next = ST_LOAD;
          else if (finish) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (block_full) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: if (cnt == 7'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!msg_end) state_next = ST_IDLE;
        else if (len_phase) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT: if (!out_stall && oidx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid = (state == ST_EMIT);
    digest_word = chain[oidx];
    word_index = oidx;
    last_word = (oidx == 3'd7);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (wr_en) w[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= wr_byte;
    if (rst) begin
      state <= ST_IDLE;
      bit_total <= 64'd0;
      msg_end <= 1'b0;
      fin_pending <= 1'b0;
      len_phase <= 1'b0;
      cnt <= '0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= init_h(3'(i));
    end else begin
      state <= state_next;
      if (wr_en) bit_total <= bit_total + 64'd8;
      if (in_acc && finish) begin
        msg_end <= 1'b1;
        len_latch <= byte_present ? bit_total + 64'd8 : bit_total;
      end
      if (pad_step) begin
        fin_pending <= 1'b1;
        if (fin_pending && pos == LEN_POS) len_phase <= 1'b1;
      end
      case (state)
        ST_LOAD: begin
          for (int i = 0; i < 8; i++) v[i] <= chain[i];
        end
        ST_ROUND: begin
          if (cnt >= 7'd16) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
            w[15] <= ws_new;
          end else if (cnt == 7'd15) begin
            // no shift yet; window aligned at round 16
          end
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          cnt <= (cnt == 7'd63) ? 7'd0 : cnt + 7'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
        end
        ST_EMIT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= init_h(3'(i));
              bit_total <= 64'd0;
              msg_end <= 1'b0;
              fin_pending <= 1'b0;
              len_phase <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
